// ===== hdl/sdmg_pkg.sv =====
// Shared constants and types for the signed division magic number generator.
// No dependencies; imported by signed_division_magic_generator_unit.
`timescale 1ns / 1ps

package sdmg_pkg;

  // Data word width of the divisor and of the multiplier.
  localparam int unsigned DW = 32;
  // Width of the exponent counter, which runs from BASE_EXP to MAX_EXP.
  localparam int unsigned EXP_W = 6;
  localparam int unsigned SHIFT_W = 5;

  localparam logic [EXP_W-1:0] BASE_EXP   = EXP_W'(31);
  localparam logic [EXP_W-1:0] MAX_EXP    = EXP_W'(63);
  localparam logic [EXP_W-1:0] SHIFT_BIAS = EXP_W'(32);

  // Last step index of a restoring division over a DW-bit dividend.
  localparam logic [SHIFT_W-1:0] DIV_LAST = SHIFT_W'(DW - 1);

  // Result of the shared trial subtractor.
  typedef struct packed {
    logic          ge;    // minuend is at least the subtrahend
    logic [DW:0]   diff;  // minuend minus subtrahend, low bits
  } sub_res_t;

endpackage

// ===== hdl/signed_division_magic_generator_unit.sv =====
// One transaction at a time: an accepted divisor runs through three restoring divisions and the
// refinement loop, which ends on the termination check or at the exponent limit; an invalid
// divisor goes straight to the load state. The input is stalled until the result register
// is loaded. All arithmetic goes through one shared 33-bit trial subtractor. Reset (rst_n
// low, synchronous) idles the unit.
`timescale 1ns / 1ps

// Top level: sequencer plus shared subtractor that computes the magic multiplier and
// post-shift for signed division by a constant. Depends on sdmg_pkg.
module signed_division_magic_generator_unit
  import sdmg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [DW-1:0] in_divisor,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [DW-1:0] out_multiplier,
  output logic [SHIFT_W-1:0]  out_post_shift,
  output logic                out_invalid
);

  // Sequencer states. The three divisions share the same step logic; the refinement
  // loop alternates between a step on the divisor pair and a step on the anc pair.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVT = 3'd1;  // t mod |d|
  localparam logic [2:0] S_ANC  = 3'd2;  // anc = t - 1 - (t mod |d|)
  localparam logic [2:0] S_DIVA = 3'd3;  // 2^31 / anc
  localparam logic [2:0] S_DIVD = 3'd4;  // 2^31 / |d|
  localparam logic [2:0] S_R2   = 3'd5;  // termination check, then step on q2/r2
  localparam logic [2:0] S_R1   = 3'd6;  // step on q1/r1
  localparam logic [2:0] S_FIN  = 3'd7;  // load the result register

  logic [2:0]         state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic               inv_r, inv_nxt;
  logic [DW-1:0]      ad_r, ad_nxt;
  logic [DW-1:0]      anc_r, anc_nxt;
  // Division working registers: partial remainder, quotient and dividend shifter.
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [SHIFT_W-1:0] cnt_r, cnt_nxt;
  // Refinement pairs. q1 needs one extra bit on the step that ends the search;
  // q2 only feeds the low word of the multiplier, so it wraps harmlessly.
  logic [DW:0]        q1_r, q1_nxt;
  logic [DW-1:0]      r1_r, r1_nxt;
  logic [DW-1:0]      q2_r, q2_nxt;
  logic [DW-1:0]      r2_r, r2_nxt;
  logic [DW-1:0]      delta_r, delta_nxt;
  logic [EXP_W-1:0]   p_r, p_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_mult_r, out_mult_nxt;
  logic [SHIFT_W-1:0]  out_shift_r, out_shift_nxt;
  logic                out_inv_r, out_inv_nxt;

  // Shared trial subtractor.
  logic [DW:0]   su_a;
  logic [DW-1:0] su_b;
  logic [DW+1:0] su_full;
  sub_res_t      su;

  logic [DW-1:0] in_abs;
  logic          in_bad;
  logic          brk;
  logic          out_free;
  logic [DW-1:0] t_m1;
  logic [EXP_W-1:0] p_inc;
  logic [EXP_W-1:0] shift_full;

  assign su_full = {1'b0, su_a} - {2'b00, su_b};
  assign su      = {~su_full[DW+1], su_full[DW:0]};

  // t - 1 is 2^31 - 1 for positive divisors and 2^31 for negative ones.
  assign t_m1 = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

  assign in_abs = in_divisor[DW-1] ? (~in_divisor + DW'(1)) : in_divisor;
  // Zero, plus or minus one, and the most negative value have no magic number.
  assign in_bad = (in_abs < DW'(2)) || (in_divisor == {1'b1, {(DW-1){1'b0}}});

  // The search ends once q1 passes |d| - r2, or meets it with a nonzero r1.
  assign brk = (q1_r > {1'b0, delta_r}) ||
               ((q1_r == {1'b0, delta_r}) && (r1_r != '0));

  assign p_inc      = p_r + EXP_W'(1);
  assign shift_full = p_r - SHIFT_BIAS;
  assign out_free   = ~out_valid_r | ~out_stall;

  always_comb begin
    unique case (state_r)
      S_DIVT, S_DIVA, S_DIVD: begin
        su_a = {rem_r, dvd_r[DW-1]};
        su_b = (state_r == S_DIVA) ? anc_r : ad_r;
      end
      S_ANC: begin
        su_a = {1'b0, t_m1};
        su_b = rem_r;
      end
      S_R2: begin
        su_a = {r2_r, 1'b0};
        su_b = ad_r;
      end
      S_R1: begin
        su_a = {r1_r, 1'b0};
        su_b = anc_r;
      end
      default: begin
        su_a = '0;
        su_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    inv_nxt       = inv_r;
    ad_nxt        = ad_r;
    anc_nxt       = anc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    q1_nxt        = q1_r;
    r1_nxt        = r1_r;
    q2_nxt        = q2_r;
    r2_nxt        = r2_r;
    delta_nxt     = delta_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_mult_nxt  = out_mult_r;
    out_shift_nxt = out_shift_r;
    out_inv_nxt   = out_inv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt = in_divisor[DW-1];
          ad_nxt  = in_abs;
          inv_nxt = in_bad;
          rem_nxt = '0;
          quo_nxt = '0;
          // Dividend t = 2^31 plus the sign bit.
          dvd_nxt = {1'b1, {(DW-2){1'b0}}, in_divisor[DW-1]};
          cnt_nxt = '0;
          state_nxt = in_bad ? S_FIN : S_DIVT;
        end
      end
      S_DIVT, S_DIVA, S_DIVD: begin
        rem_nxt = su.ge ? su.diff[DW-1:0] : su_a[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], su.ge};
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        cnt_nxt = cnt_r + SHIFT_W'(1);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          if (state_r == S_DIVT) begin
            state_nxt = S_ANC;
          end else begin
            rem_nxt = '0;
            quo_nxt = '0;
            dvd_nxt = {1'b1, {(DW-1){1'b0}}};
            if (state_r == S_DIVA) begin
              q1_nxt    = {1'b0, quo_r[DW-2:0], su.ge};
              r1_nxt    = su.ge ? su.diff[DW-1:0] : su_a[DW-1:0];
              state_nxt = S_DIVD;
            end else begin
              q2_nxt    = {quo_r[DW-2:0], su.ge};
              r2_nxt    = su.ge ? su.diff[DW-1:0] : su_a[DW-1:0];
              p_nxt     = BASE_EXP;
              state_nxt = S_R2;
            end
          end
        end
      end
      S_ANC: begin
        anc_nxt   = su.diff[DW-1:0];
        rem_nxt   = '0;
        quo_nxt   = '0;
        dvd_nxt   = {1'b1, {(DW-1){1'b0}}};
        state_nxt = S_DIVA;
      end
      S_R2: begin
        // No check before the first refinement step.
        if ((p_r != BASE_EXP) && brk) begin
          state_nxt = S_FIN;
        end else begin
          q2_nxt    = {q2_r[DW-2:0], su.ge};
          r2_nxt    = su.ge ? su.diff[DW-1:0] : su_a[DW-1:0];
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        q1_nxt    = {q1_r[DW-1:0], su.ge};
        r1_nxt    = su.ge ? su.diff[DW-1:0] : su_a[DW-1:0];
        delta_nxt = ad_r - r2_r;
        p_nxt     = p_inc;
        state_nxt = (p_inc == MAX_EXP) ? S_FIN : S_R2;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = inv_r;
          if (inv_r) begin
            out_mult_nxt  = '0;
            out_shift_nxt = '0;
          end else begin
            // -(q2 + 1) equals ~q2 in two's complement.
            out_mult_nxt  = neg_r ? ~q2_r : (q2_r + DW'(1));
            out_shift_nxt = shift_full[SHIFT_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    inv_r       <= inv_nxt;
    ad_r        <= ad_nxt;
    anc_r       <= anc_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dvd_r       <= dvd_nxt;
    cnt_r       <= cnt_nxt;
    q1_r        <= q1_nxt;
    r1_r        <= r1_nxt;
    q2_r        <= q2_nxt;
    r2_r        <= r2_nxt;
    delta_r     <= delta_nxt;
    p_r         <= p_nxt;
    out_mult_r  <= out_mult_nxt;
    out_shift_r <= out_shift_nxt;
    out_inv_r   <= out_inv_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_multiplier = out_mult_r;
  assign out_post_shift = out_shift_r;
  assign out_invalid    = out_inv_r;

  // An invalid divisor always reports zero multiplier and shift.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_multiplier == '0 && out_post_shift == '0))
    else $error("invalid result carries nonzero fields");

  // Refinement remainders stay below their divisors.
  a_r2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R2 || state_r == S_R1) |-> (r2_r < ad_r))
    else $error("r2 not below |d|");

  a_r1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R2 || state_r == S_R1) |-> (r1_r < anc_r))
    else $error("r1 not below anc");

  // A new result only appears after the load state.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the load state");

endmodule
